### rtl/kfil_pkg.sv
// shared types and constants for the keyframe interval interpolator
`default_nettype none
package kfil_pkg;
    localparam int VAL_W   = 32;
    localparam int FRAME_W = 16;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;

    localparam logic [MODE_W-1:0] MODE_TRANS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCALE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVAL  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_STORED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_RESULT  = 2'd2;

    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_POS_Z   = 3'd2;
    localparam logic [2:0] REG_SCALE_X = 3'd3;
    localparam logic [2:0] REG_SCALE_Y = 3'd4;
    localparam logic [2:0] REG_SCALE_Z = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_RD,
        S_WAIT,
        S_SCAN,
        S_DIV,
        S_CRD,
        S_CWAIT,
        S_MUL,
        S_ACC,
        S_NEXTTRK,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

### rtl/kfil_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module kfil_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [kfil_pkg::FRAME_W-1:0]     i_num,
    input  wire logic [kfil_pkg::FRAME_W-1:0]     i_den,
    output logic                                  o_done,
    output logic [kfil_pkg::FRAME_W+FRAC_BITS-1:0] o_quot
);
    import kfil_pkg::*;
    localparam int QW = FRAME_W + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]    r_quot, n_quot;
    logic [FRAME_W:0] r_rem, n_rem;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [FRAME_W:0] w_trial;

    // load the operands on start, then shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = '0;
        if (i_start) begin
            n_quot = {i_num, {FRAC_BITS{1'b0}}};
            n_rem  = '0;
            n_cnt  = CW'(QW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            w_trial = {r_rem[FRAME_W-1:0], r_quot[QW-1]};
            n_quot  = {r_quot[QW-2:0], 1'b0};
            if (w_trial >= {1'b0, i_den}) begin
                n_rem     = w_trial - {1'b0, i_den};
                n_quot[0] = 1'b1;
            end else begin
                n_rem = w_trial;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

### rtl/keyframe_interval_lerp.sv
// top level: interval tables, scan sequencer and shared blend datapath
// sequence: a load writes the frame pair and its coordinate words, then offers the
//   result word (straight away when the table is full); an evaluate scans each track's
//   intervals in turn, then copies an end vector or blends (serial divide, one multiply
//   per axis); one item at a time, the next accepted after the result is taken
// reset: synchronous active low; counts cleared, init registers 0 and 1.0, tables kept
`default_nettype none
module keyframe_interval_lerp #(
    parameter int MAX_INTERVALS = 16,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // mode[1:0], frame[17:2], end_frame[33:18], start_x..end_z[225:34], zero pad
    input  wire logic [231:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[1:0], pos_x/y/z, scale_x/y/z[193:2], zero pad
    output logic [199:0]      m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data
);
    import kfil_pkg::*;
    localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int NW = $clog2(MAX_INTERVALS + 1);
    localparam int QW = FRAME_W + FRAC_BITS;
    localparam int FD = 2 * (1 << IW);
    localparam int FAW = $clog2(FD);
    localparam int CD = FD * 6;
    localparam int CAW = $clog2(CD);

    // config registers
    logic signed [VAL_W-1:0] r_init [6];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init[0] <= '0; r_init[1] <= '0; r_init[2] <= '0;
            r_init[3] <= 32'sd65536; r_init[4] <= 32'sd65536; r_init[5] <= 32'sd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POS_X:   r_init[0] <= i_cfg_data;
                REG_POS_Y:   r_init[1] <= i_cfg_data;
                REG_POS_Z:   r_init[2] <= i_cfg_data;
                REG_SCALE_X: r_init[3] <= i_cfg_data;
                REG_SCALE_Y: r_init[4] <= i_cfg_data;
                REG_SCALE_Z: r_init[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memories: frame pairs and coordinate words for both tracks
    logic [2*FRAME_W-1:0] m_frames [FD];
    logic [VAL_W-1:0]     m_coords [CD];
    logic                 w_fwe, w_cwe;
    logic [FAW-1:0]       w_faddr;
    logic [CAW-1:0]       w_caddr, w_crad;
    logic [2*FRAME_W-1:0] r_frd, w_fwd;
    logic [VAL_W-1:0]     r_crd, w_cwd;
    always_ff @(posedge i_clk) begin
        if (w_fwe) m_frames[w_faddr] <= w_fwd;
        r_frd <= m_frames[w_faddr];
    end
    always_ff @(posedge i_clk) begin
        if (w_cwe) m_coords[w_caddr] <= w_cwd;
        r_crd <= m_coords[w_crad];
    end

    // item registers and sequencer state
    t_state r_st, n_st;
    logic [MODE_W-1:0]  r_mode;
    logic [FRAME_W-1:0] r_frame, r_endf;
    logic [VAL_W-1:0]   r_vin [6];
    logic [NW-1:0] r_cnt [2];
    logic          r_trk;
    logic [NW-1:0] r_idx;
    logic [2:0]    r_j;
    logic          r_seen, r_hit, r_zero;
    logic [FRAME_W-1:0] r_best, r_s, r_e;
    logic [IW-1:0] r_bidx;
    logic [VAL_W-1:0] r_res [6];
    logic signed [VAL_W-1:0] r_a;
    logic signed [VAL_W+QW+1:0] r_prod;
    logic [STAT_W-1:0] r_stat;
    logic [QW-1:0] w_quot;
    logic w_ddone, w_dstart;

    kfil_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(r_frame - r_s), .i_den(r_e - r_s),
        .o_done(w_ddone), .o_quot(w_quot)
    );
    logic [QW-1:0] r_t;

    logic w_full;
    assign w_full = (r_cnt[r_mode[0]] >= NW'(MAX_INTERVALS));
    logic [IW-1:0] w_ix;
    assign w_ix = r_idx[IW-1:0];
    logic [IW-1:0] w_cur;
    assign w_cur = r_hit ? w_ix : r_bidx;

    // memory address selection; a blend reads the start word, then the end word
    always_comb begin
        w_fwe = (r_st == S_LOAD) && !w_full;
        w_cwe = w_fwe;
        w_fwd = {r_endf, r_frame};
        w_cwd = r_vin[0];
        if (r_st == S_LOAD) begin
            w_faddr = {r_mode[0], r_cnt[r_mode[0]][IW-1:0]};
        end else begin
            w_faddr = {r_trk, w_ix};
        end
        w_caddr = CAW'((({r_mode[0], r_cnt[r_mode[0]][IW-1:0]}) * 6) + r_j);
        w_crad  = CAW'(({r_trk, w_cur} * 6) +
                       ((r_hit && !r_zero && r_st != S_CWAIT) ? 3'd0 : 3'd3) + r_j);
        if (r_st == S_LOAD) w_crad = w_caddr;
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:    if (s_axis_tvalid) n_st = (s_axis_tdata[1:0] == MODE_EVAL) ? S_RD :
                           (s_axis_tdata[1:0] == MODE_NONE ? S_IDLE : S_LOAD);
            S_LOAD:    n_st = (w_full || r_j == 3'd5) ? S_OUT : S_LOAD;
            S_RD:      n_st = (r_idx >= r_cnt[r_trk]) ? (r_seen ? S_CRD : S_NEXTTRK) : S_WAIT;
            S_WAIT:    n_st = S_SCAN;
            S_SCAN:    n_st = S_RD;
            S_DIV:     n_st = w_ddone ? S_CRD : S_DIV;
            S_CRD:     n_st = S_CWAIT;
            S_CWAIT:   n_st = (r_hit && !r_zero) ? S_MUL : S_ACC;
            S_MUL:     n_st = S_ACC;
            S_ACC:     n_st = (r_j == 3'd2) ? S_NEXTTRK : S_CRD;
            S_NEXTTRK: n_st = r_trk ? S_OUT : S_RD;
            S_OUT:     n_st = m_axis_tready ? S_IDLE : S_OUT;
            default:   n_st = S_IDLE;
        endcase
        // a containing interval leaves the scan early
        if (r_st == S_SCAN && r_frame >= r_s && r_frame <= r_e) begin
            n_st = (r_s == r_e) ? S_CRD : S_DIV;
        end
    end

    assign w_dstart = (r_st == S_SCAN) && (n_st == S_DIV);
    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = (r_st == S_OUT);
    assign m_axis_tdata = {6'd0, r_res[5], r_res[4], r_res[3], r_res[2], r_res[1],
                           r_res[0], r_stat};

    logic signed [VAL_W:0] w_diff;
    logic signed [VAL_W+QW+1:0] w_fl;
    assign w_diff = $signed({r_crd[VAL_W-1], r_crd}) - $signed({r_a[VAL_W-1], r_a});
    assign w_fl = r_prod >>> FRAC_BITS;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == S_LOAD && !w_full && r_j == 3'd5)
                r_cnt[r_mode[0]] <= r_cnt[r_mode[0]] + 1'b1;
        end
        unique case (r_st)
            S_IDLE: begin
                r_mode  <= s_axis_tdata[1:0];
                r_frame <= s_axis_tdata[17:2];
                r_endf  <= s_axis_tdata[33:18];
                for (int k = 0; k < 6; k++) r_vin[k] <= s_axis_tdata[34+32*k +: 32];
                r_j <= '0; r_trk <= 1'b0; r_idx <= '0;
                r_seen <= 1'b0; r_hit <= 1'b0; r_zero <= 1'b0;
                r_bidx <= '0; r_best <= '0;
                for (int k = 0; k < 6; k++) r_res[k] <= r_init[k];
            end
            S_LOAD: begin
                r_stat <= w_full ? ST_FULL : ST_STORED;
                for (int k = 0; k < 6; k++) r_res[k] <= '0;
                for (int k = 0; k < 5; k++) r_vin[k] <= r_vin[k+1];
                r_j <= r_j + 1'b1;
            end
            // frame pair is on the read port, hold it for the scan and the divider
            S_WAIT: begin
                r_s <= r_frd[FRAME_W-1:0];
                r_e <= r_frd[2*FRAME_W-1:FRAME_W];
            end
            S_SCAN: begin
                if (r_frame >= r_frd[FRAME_W-1:0] && r_frame <= r_frd[2*FRAME_W-1:FRAME_W]) begin
                    r_hit  <= 1'b1;
                    r_zero <= (r_frd[FRAME_W-1:0] == r_frd[2*FRAME_W-1:FRAME_W]);
                end else begin
                    if (r_frame >= r_frd[2*FRAME_W-1:FRAME_W] &&
                        (!r_seen || r_frd[2*FRAME_W-1:FRAME_W] > r_best)) begin
                        r_seen <= 1'b1;
                        r_best <= r_frd[2*FRAME_W-1:FRAME_W];
                        r_bidx <= w_ix;
                    end
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_DIV: r_t <= w_quot;
            S_CRD: ;
            S_CWAIT: begin
                if (r_hit && !r_zero)
                    r_a <= r_crd;
            end
            S_MUL: begin
                r_prod <= (VAL_W+QW+2)'(w_diff * $signed({1'b0, r_t}));
            end
            S_ACC: begin
                if (r_hit && !r_zero)
                    r_res[{r_trk, 2'b00} == 3'd0 ? r_j : r_j + 3'd3] <=
                        VAL_W'(r_a + w_fl[VAL_W-1:0]);
                else
                    r_res[r_trk ? r_j + 3'd3 : r_j] <= r_crd;
                r_j <= r_j + 1'b1;
            end
            S_NEXTTRK: begin
                r_trk <= 1'b1; r_idx <= '0; r_j <= '0;
                r_seen <= 1'b0; r_hit <= 1'b0; r_zero <= 1'b0;
                r_best <= '0; r_bidx <= '0;
                r_stat <= ST_RESULT;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
